FILE: sv/irn_pkg.sv
package irn_pkg;

  localparam int MAX_SOURCE_WIDTH  = 128;
  localparam int MAX_SOURCE_HEIGHT = 128;
  localparam int FRACTION_BITS     = 14;

  localparam int FRAME_DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int ADDR_BITS   = $clog2(FRAME_DEPTH);

  localparam int COORD_BITS = 9;
  localparam int COEF_BITS  = 16;
  localparam int PROD_BITS  = COORD_BITS + COEF_BITS;
  localparam int SUM_BITS   = ((FRACTION_BITS + 8 > PROD_BITS + 1) ?
                               FRACTION_BITS + 8 : PROD_BITS + 1) + 1;
  localparam int Q_BITS     = SUM_BITS - FRACTION_BITS;

  localparam logic [7:0] WHITE_LEVEL = 8'd255;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COSINE        = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SINE          = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_WIDTH    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_HEIGHT   = 3'd5;

  typedef struct packed {
    logic       kind;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       outside;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [23:0] pixel;
  } tag_t;

  typedef struct packed {
    logic                 valid;
    logic                 query;
    logic                 write;
    logic                 outside;
    logic [ADDR_BITS-1:0] addr;
    logic [23:0]          pixel;
  } access_t;

  typedef struct packed {
    logic valid;
    logic outside;
  } read_t;

endpackage

FILE: sv/irn_map.sv
module irn_map (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   accept,
  input  irn_pkg::item_t                         item,
  input  logic signed [irn_pkg::COEF_BITS-1:0]   cosine_q14,
  input  logic signed [irn_pkg::COEF_BITS-1:0]   sine_q14,
  input  logic [7:0]                             sw,
  input  logic [7:0]                             sh,
  input  logic [7:0]                             dest_width,
  input  logic [7:0]                             dest_height,
  output irn_pkg::access_t                       access
);

  localparam int SB = irn_pkg::SUM_BITS;
  localparam int FB = irn_pkg::FRACTION_BITS;
  localparam int QB = irn_pkg::Q_BITS;
  localparam int AB = irn_pkg::ADDR_BITS;
  localparam logic [SB-1:0] BIAS = SB'((1 << FB) - 1);

  irn_pkg::tag_t tag1, tag2, tag3;

  logic signed [irn_pkg::COORD_BITS-1:0] x1, y1;
  logic signed [irn_pkg::PROD_BITS-1:0]  xc2, ys2, xs2, yc2;
  logic signed [SB-1:0]                  px3, py3;

  logic [SB-1:0]        offset_x, offset_y;
  logic signed [SB-1:0] rx, ry;
  logic [QB-1:0]        qx, qy;
  logic                 q_out;
  logic                 load_ok;
  logic [AB-1:0]        q_addr, l_addr;

  assign offset_x = SB'(sw[7:1]) << FB;
  assign offset_y = SB'(sh[7:1]) << FB;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid   <= 1'b0;
      tag2.valid   <= 1'b0;
      tag3.valid   <= 1'b0;
      access.valid <= 1'b0;
    end else begin
      tag1.valid   <= accept;
      tag2.valid   <= tag1.valid;
      tag3.valid   <= tag2.valid;
      access.valid <= tag3.valid;
    end
    tag1.kind   <= item.kind;
    tag1.column <= item.column;
    tag1.row    <= item.row;
    tag1.pixel  <= {item.red_in, item.green_in, item.blue_in};
    x1 <= $signed({1'b0, item.column}) - $signed({2'b00, dest_width[7:1]});
    y1 <= $signed({1'b0, item.row}) - $signed({2'b00, dest_height[7:1]});

    {tag2.kind, tag2.column, tag2.row, tag2.pixel} <=
      {tag1.kind, tag1.column, tag1.row, tag1.pixel};
    xc2 <= x1 * cosine_q14;
    ys2 <= y1 * sine_q14;
    xs2 <= x1 * sine_q14;
    yc2 <= y1 * cosine_q14;

    {tag3.kind, tag3.column, tag3.row, tag3.pixel} <=
      {tag2.kind, tag2.column, tag2.row, tag2.pixel};
    px3 <= SB'(xc2) - SB'(ys2) + offset_x;
    py3 <= SB'(xs2) + SB'(yc2) + offset_y;

    access.query   <= (tag3.kind == irn_pkg::KIND_QUERY);
    access.write   <= (tag3.kind == irn_pkg::KIND_LOAD) && load_ok;
    access.outside <= q_out;
    access.addr    <= (tag3.kind == irn_pkg::KIND_QUERY) ? q_addr : l_addr;
    access.pixel   <= tag3.pixel;
  end

  // truncate toward zero
  always_comb begin
    rx = px3 + (px3[SB-1] ? BIAS : '0);
    ry = py3 + (py3[SB-1] ? BIAS : '0);
    qx = rx[SB-1:FB];
    qy = ry[SB-1:FB];
    q_out = qx[QB-1] || qy[QB-1] || (qx >= QB'(sw)) || (qy >= QB'(sh));
    q_addr = AB'(qy) * AB'(irn_pkg::MAX_SOURCE_WIDTH) + AB'(qx);
    l_addr = AB'(tag3.row) * AB'(irn_pkg::MAX_SOURCE_WIDTH) + AB'(tag3.column);
    load_ok = (32'(tag3.column) < irn_pkg::MAX_SOURCE_WIDTH) &&
              (32'(tag3.row) < irn_pkg::MAX_SOURCE_HEIGHT);
  end

endmodule

FILE: sv/irn_frame.sv
module irn_frame (
  input  logic             clk,
  input  logic             rst,
  input  irn_pkg::access_t access,
  output irn_pkg::read_t   rd,
  output logic [23:0]      rdata
);

  logic [23:0] mem [irn_pkg::FRAME_DEPTH];

  always_ff @(posedge clk) begin
    if (access.valid && access.write) begin
      mem[access.addr] <= access.pixel;
    end
    if (access.valid && access.query && !access.outside) begin
      rdata <= mem[access.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd.valid <= 1'b0;
    end else begin
      rd.valid <= access.valid && access.query;
    end
    rd.outside <= access.outside;
  end

endmodule

FILE: sv/image_rotate_nearest.sv
// channel   direction  handshake             payload
// item      in         start & !busy         irn_pkg::item_t
// result    out        done, one cycle       irn_pkg::result_t
// config    in         cfg_valid & cfg_ready cfg_index, cfg_data
//
// one item enters per cycle while busy is low
// a query result passes the center, multiply, sum, truncate, frame read and output stages
// loads and queries share the frame port in order, so no forwarding is needed
// busy is high only during reset and the cycle after; the frame is not cleared
// results cannot be stalled by the receiver
module image_rotate_nearest (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  irn_pkg::item_t                           item,
  output logic                                     done,
  output irn_pkg::result_t                         result,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [irn_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [15:0]                              cfg_data
);

  logic signed [irn_pkg::COEF_BITS-1:0] cosine_q14, sine_q14;
  logic [7:0] source_width, source_height, dest_width, dest_height;
  logic [7:0] sw, sh;

  irn_pkg::access_t access;
  irn_pkg::read_t   rd;
  logic [23:0]      rdata;

  assign cfg_ready = 1'b1;

  assign sw = (32'(source_width) < irn_pkg::MAX_SOURCE_WIDTH) ?
              source_width : 8'(irn_pkg::MAX_SOURCE_WIDTH);
  assign sh = (32'(source_height) < irn_pkg::MAX_SOURCE_HEIGHT) ?
              source_height : 8'(irn_pkg::MAX_SOURCE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b1;
      cosine_q14    <= 16'sd16384;
      sine_q14      <= 16'sd0;
      source_width  <= 8'd128;
      source_height <= 8'd128;
      dest_width    <= 8'd128;
      dest_height   <= 8'd128;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          irn_pkg::REG_COSINE:        cosine_q14    <= cfg_data;
          irn_pkg::REG_SINE:          sine_q14      <= cfg_data;
          irn_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data[7:0];
          irn_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data[7:0];
          irn_pkg::REG_DEST_WIDTH:    dest_width    <= cfg_data[7:0];
          irn_pkg::REG_DEST_HEIGHT:   dest_height   <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  irn_map u_map (
    .clk         (clk),
    .rst         (rst),
    .accept      (start && !busy),
    .item        (item),
    .cosine_q14  (cosine_q14),
    .sine_q14    (sine_q14),
    .sw          (sw),
    .sh          (sh),
    .dest_width  (dest_width),
    .dest_height (dest_height),
    .access      (access)
  );

  irn_frame u_frame (
    .clk    (clk),
    .rst    (rst),
    .access (access),
    .rd     (rd),
    .rdata  (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rd.valid;
    end
    if (rd.outside) begin
      result <= {irn_pkg::WHITE_LEVEL, irn_pkg::WHITE_LEVEL, irn_pkg::WHITE_LEVEL, 1'b1};
    end else begin
      result <= {rdata, 1'b0};
    end
  end

endmodule

FILE: sv/irn_checker.sv
module irn_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input irn_pkg::item_t   item,
  input logic             done,
  input irn_pkg::result_t result
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_ready_after_reset: assert property (@(posedge clk) !rst |=> !busy)
    else $error("busy outside reset");

  a_white_fill: assert property (@(posedge clk) disable iff (rst)
    (done && result.outside) |->
      (result.red_out == irn_pkg::WHITE_LEVEL && result.green_out == irn_pkg::WHITE_LEVEL &&
       result.blue_out == irn_pkg::WHITE_LEVEL))
    else $error("outside result not white");

  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (item.kind == irn_pkg::KIND_QUERY), 6))
    else $error("result without matching query transfer");

endmodule

bind image_rotate_nearest irn_checker u_irn_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
